// ===== rtl/core/irdal_pkg.sv =====
// ----------------------------------------------------------------------------
// irdal_pkg
// Shared types, constants and breakpoint tables for the infrared distance
// averaging and linearization block.
// ----------------------------------------------------------------------------
`default_nettype none

package irdal_pkg;

  // Default width of a converter sample.
  localparam int unsigned SampleBitsDefault = 10;

  // Accumulator, mean and divider widths.
  localparam int unsigned SumW     = 16;
  localparam int unsigned CountW   = 6;
  localparam int unsigned DivisorW = 12;
  localparam int unsigned DistW    = 7;
  localparam int unsigned MeanOutW = 10;
  localparam int unsigned SegIdxW  = 3;
  localparam int unsigned SegDistW = 8;

  // One quotient bit is resolved per divider step.
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  localparam logic [CountW-1:0] CountReset = CountW'(20);
  localparam logic [SumW-1:0]   MeanFloor  = SumW'(80);
  localparam logic [DistW-1:0]  DistMax    = DistW'(80);
  localparam int unsigned       NumSegs    = 7;

  // The segment with a slope of exactly two counts per centimeter.
  localparam logic [SegIdxW-1:0] SegHalf = SegIdxW'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MAP,
    ST_DROP,
    ST_OUT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [SumW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

  // Segment lookup result for one mean value.
  typedef struct packed {
    logic                low;
    logic                high;
    logic                exact;
    logic [SegIdxW-1:0]  idx;
    logic [SegDistW-1:0] delta;
  } seg_t;

  // Upper breakpoint of each segment.
  function automatic logic [SumW-1:0] bp_hi(input logic [SegIdxW-1:0] idx);
    logic [SumW-1:0] v;
    case (idx)
      3'd0:    v = SumW'(87);
      3'd1:    v = SumW'(106);
      3'd2:    v = SumW'(124);
      3'd3:    v = SumW'(150);
      3'd4:    v = SumW'(196);
      3'd5:    v = SumW'(276);
      default: v = SumW'(490);
    endcase
    return v;
  endfunction

  // Lower breakpoint of each segment.
  function automatic logic [SumW-1:0] bp_lo(input logic [SegIdxW-1:0] idx);
    logic [SumW-1:0] v;
    case (idx)
      3'd0:    v = SumW'(80);
      3'd1:    v = SumW'(87);
      3'd2:    v = SumW'(106);
      3'd3:    v = SumW'(124);
      3'd4:    v = SumW'(150);
      3'd5:    v = SumW'(196);
      default: v = SumW'(276);
    endcase
    return v;
  endfunction

  // Distance at each breakpoint, in centimeters.
  function automatic logic [DistW-1:0] bp_cm(input logic [SegIdxW-1:0] idx);
    logic [DistW-1:0] v;
    case (idx)
      3'd0:    v = DistW'(80);
      3'd1:    v = DistW'(70);
      3'd2:    v = DistW'(60);
      3'd3:    v = DistW'(50);
      3'd4:    v = DistW'(40);
      3'd5:    v = DistW'(30);
      3'd6:    v = DistW'(20);
      default: v = DistW'(10);
    endcase
    return v;
  endfunction

  // Segment slope in hundredths of a count per centimeter.
  function automatic logic [DivisorW-1:0] slope(input logic [SegIdxW-1:0] idx);
    logic [DivisorW-1:0] v;
    case (idx)
      3'd0:    v = DivisorW'(77);
      3'd1:    v = DivisorW'(211);
      3'd2:    v = DivisorW'(200);
      3'd3:    v = DivisorW'(288);
      3'd4:    v = DivisorW'(511);
      3'd5:    v = DivisorW'(888);
      default: v = DivisorW'(2377);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/irdal_divider.sv =====
// ----------------------------------------------------------------------------
// irdal_divider
// Shared restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module irdal_divider (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire irdal_pkg::div_req_t   req_i,
  output irdal_pkg::div_rsp_t        rsp_o
);

  localparam int unsigned SumW     = irdal_pkg::SumW;
  localparam int unsigned DivisorW = irdal_pkg::DivisorW;
  localparam int unsigned StepCntW = irdal_pkg::StepCntW;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(irdal_pkg::DivSteps - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [SumW-1:0]     quo_q, quo_d;

  logic [DivisorW:0] shifted;
  logic [DivisorW:0] diff;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[SumW-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = shifted >= {1'b0, dsr_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      quo_d = {quo_q[SumW-2:0], fits};
      cnt_d = cnt_q + StepCntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/irdal_segment.sv =====
// ----------------------------------------------------------------------------
// irdal_segment
// Locates the linearization segment that holds a mean value.
// ----------------------------------------------------------------------------
`default_nettype none

module irdal_segment (
  input  wire [irdal_pkg::SumW-1:0] mean_i,
  output irdal_pkg::seg_t           seg_o
);

  localparam int unsigned SumW    = irdal_pkg::SumW;
  localparam int unsigned SegIdxW = irdal_pkg::SegIdxW;

  logic               found;
  logic [SegIdxW-1:0] idx;
  logic [SumW-1:0]    dist_full;

  // Pick the first segment whose upper breakpoint is at or above the mean.
  always_comb begin
    found = 1'b0;
    idx   = SegIdxW'(irdal_pkg::NumSegs - 1);
    for (int k = irdal_pkg::NumSegs - 1; k >= 0; k--) begin
      if (mean_i <= irdal_pkg::bp_hi(SegIdxW'(k))) begin
        found = 1'b1;
        idx   = SegIdxW'(k);
      end
    end
    dist_full = mean_i - irdal_pkg::bp_lo(idx);
  end

  assign seg_o.low   = mean_i <= irdal_pkg::MeanFloor;
  assign seg_o.high  = !found;
  assign seg_o.exact = mean_i == irdal_pkg::bp_hi(idx);
  assign seg_o.idx   = idx;
  assign seg_o.delta = dist_full[irdal_pkg::SegDistW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/ir_distance_average_linearize.sv =====
// A sample that does not close a group is taken and yields nothing. A closing
// sample passes the mean division in ST_MEAN, ST_MAP, a slope division in
// ST_DROP when the segment needs one, and ST_OUT, which waits for the output.
// Throughput: one sample per cycle inside a group; no sample is taken while
// a closing sample is in progress (one or two 16-step shared divisions).
// Reset: asynchronous, active low; clears the sum, the count, the held
// distance and the output valid, and sets the sample count to 20.
// ----------------------------------------------------------------------------
// ir_distance_average_linearize
// Averages a configurable number of infrared sensor samples and converts the
// mean to centimeters on piecewise-linear segments.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_distance_average_linearize #(
  parameter int unsigned SAMPLE_BITS = irdal_pkg::SampleBitsDefault
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Configuration: samples averaged per result.
  input  wire                             cfg_we_i,
  input  wire [irdal_pkg::CountW-1:0]     cfg_data_i,
  // Sample channel.
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire [SAMPLE_BITS-1:0]           sample_i,
  // Result channel.
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [irdal_pkg::DistW-1:0]     distance_cm_o,
  output logic [irdal_pkg::MeanOutW-1:0]  mean_value_o,
  output logic                            out_of_range_o
);

  localparam int unsigned SumW     = irdal_pkg::SumW;
  localparam int unsigned CountW   = irdal_pkg::CountW;
  localparam int unsigned DivisorW = irdal_pkg::DivisorW;
  localparam int unsigned DistW    = irdal_pkg::DistW;
  localparam int unsigned MeanOutW = irdal_pkg::MeanOutW;
  localparam int unsigned SegIdxW  = irdal_pkg::SegIdxW;

  irdal_pkg::state_e state_q, state_d;

  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] seen_q, seen_d;
  logic [DistW-1:0]  last_q, last_d;
  logic [SumW-1:0]   mean_q, mean_d;
  logic [DistW-1:0]  cm_q, cm_d;
  logic              ok_q, ok_d;

  logic                out_valid_q, out_valid_d;
  logic [DistW-1:0]    out_dist_q, out_dist_d;
  logic [MeanOutW-1:0] out_mean_q, out_mean_d;
  logic                out_oor_q, out_oor_d;

  irdal_pkg::div_req_t div_req;
  irdal_pkg::div_rsp_t div_rsp;
  irdal_pkg::seg_t     seg;

  logic [SumW-1:0]   sum_next;
  logic [CountW-1:0] n_next;
  logic [CountW-1:0] need;
  logic [SumW-1:0]   dist_ext;
  logic [SumW-1:0]   drop_num;
  logic [DistW-1:0]  base_cm;
  logic [DistW-1:0]  held_dist;

  // The one shared arithmetic unit: it forms the mean first and then, for
  // most segments, the rounded-up distance drop inside the segment.
  irdal_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  irdal_segment u_segment (
    .mean_i (mean_q),
    .seg_o  (seg)
  );

  // A count of zero behaves as a count of one.
  assign need     = (count_q == '0) ? CountW'(1) : count_q;
  assign sum_next = sum_q + SumW'(sample_i);
  assign n_next   = seen_q + CountW'(1);

  // Ceiling division numerator: d * 100 + K - 1, with d * 100 built from
  // shifts (64 + 32 + 4).
  assign dist_ext = SumW'(seg.delta);
  assign drop_num = (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2)
                  + SumW'(irdal_pkg::slope(seg.idx)) - SumW'(1);
  assign base_cm  = irdal_pkg::bp_cm(seg.idx);
  assign held_dist = ok_q ? cm_q : last_q;

  always_comb begin
    state_d     = state_q;
    count_d     = cfg_we_i ? cfg_data_i : count_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    last_d      = last_q;
    mean_d      = mean_q;
    cm_d        = cm_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dist_d  = out_dist_q;
    out_mean_d  = out_mean_q;
    out_oor_d   = out_oor_q;
    in_ready_o  = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    case (state_q)
      irdal_pkg::ST_IDLE: begin
        // Ready is high throughout this state, so a valid sample is taken.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (n_next < need) begin
            sum_d  = sum_next;
            seen_d = n_next;
          end else begin
            // Group complete: divide by the samples actually taken.
            sum_d            = '0;
            seen_d           = '0;
            div_req.start    = 1'b1;
            div_req.dividend = sum_next;
            div_req.divisor  = DivisorW'(n_next);
            state_d          = irdal_pkg::ST_MEAN;
          end
        end
      end
      irdal_pkg::ST_MEAN: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quotient;
          state_d = irdal_pkg::ST_MAP;
        end
      end
      irdal_pkg::ST_MAP: begin
        ok_d    = 1'b1;
        state_d = irdal_pkg::ST_OUT;
        if (seg.low) begin
          cm_d = irdal_pkg::DistMax;
        end else if (seg.high) begin
          ok_d = 1'b0;
        end else if (seg.exact) begin
          // A mean on a breakpoint takes that breakpoint's distance.
          cm_d = irdal_pkg::bp_cm(SegIdxW'(seg.idx + SegIdxW'(1)));
        end else if (seg.idx == irdal_pkg::SegHalf) begin
          cm_d = base_cm - DistW'(seg.delta >> 1);
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = drop_num;
          div_req.divisor  = irdal_pkg::slope(seg.idx);
          state_d          = irdal_pkg::ST_DROP;
        end
      end
      irdal_pkg::ST_DROP: begin
        if (div_rsp.done) begin
          cm_d    = base_cm - div_rsp.quotient[DistW-1:0];
          state_d = irdal_pkg::ST_OUT;
        end
      end
      irdal_pkg::ST_OUT: begin
        // Wait until the output register is free, then publish.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_dist_d  = held_dist;
          out_mean_d  = mean_q[MeanOutW-1:0];
          out_oor_d   = !ok_q;
          last_d      = held_dist;
          state_d     = irdal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = irdal_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irdal_pkg::ST_IDLE;
      count_q     <= irdal_pkg::CountReset;
      sum_q       <= '0;
      seen_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q     <= mean_d;
    cm_q       <= cm_d;
    ok_q       <= ok_d;
    out_dist_q <= out_dist_d;
    out_mean_q <= out_mean_d;
    out_oor_q  <= out_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign distance_cm_o  = out_dist_q;
  assign mean_value_o   = out_mean_q;
  assign out_of_range_o = out_oor_q;

`ifndef SYNTHESIS
  // The divider is never restarted while it is still iterating.
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // Once a group is closed, the accumulator stays clear until the result
  // has been published.
  a_group_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != irdal_pkg::ST_IDLE) |-> (sum_q == '0 && seen_q == '0))
    else $error("accumulator not cleared while a result is in progress");

  // A published distance never exceeds the far end of the curve.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_cm_o <= irdal_pkg::DistMax))
    else $error("distance out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the infrared distance averaging and linearization
// block. Samples go in over a valid/ready channel. A scoreboard class keeps
// its own running sum, group counter and held distance, and predicts every
// distance result. Each result that comes out is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SmpW     = irdal_pkg::SampleBitsDefault;
  localparam int unsigned CntW     = irdal_pkg::CountW;
  localparam int unsigned CmW      = irdal_pkg::DistW;
  localparam int unsigned MeanW    = irdal_pkg::MeanOutW;
  localparam int unsigned RandomSamples = 1550;
  // A transaction-free stretch longer than this means the block is hung. The
  // deliberate receiver hold-off below is far shorter.
  localparam int unsigned QuietLimit  = 5000;
  // This pause covers, with margin, both a closing sample and a sample that
  // closes nothing.
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned HoldOffCycles = 400;

  typedef struct packed {
    logic [CmW-1:0]   dist_cm;
    logic [MeanW-1:0] mean;
    logic             oor;
  } distance_result_t;

  // Predicts the block from the accepted samples. It holds its own copy of
  // the accumulator, the group position, the held distance and the sample
  // count register.
  class distance_scoreboard;
    logic [15:0]       sum_acc;
    logic [CntW-1:0]   taken;
    logic [CntW-1:0]   group_len;
    logic [CmW-1:0]    held_cm;
    distance_result_t  awaited[$];
    int unsigned       errors;

    function new();
      sum_acc   = '0;
      taken     = '0;
      group_len = CntW'(20);
      held_cm   = '0;
      errors    = 0;
    endfunction

    function void write_count(logic [CntW-1:0] v);
      group_len = v;
    endfunction

    function int unsigned drop_ceil(int unsigned d, int unsigned pct);
      return (d * 100 + pct - 1) / pct;
    endfunction

    // Piecewise-linear map from the mean to centimeters. Returns 0 when the
    // mean lies above the last breakpoint.
    function bit mean_to_cm(int unsigned mean, output logic [CmW-1:0] cm);
      cm = '0;
      if (mean <= 80)       cm = CmW'(80);
      else if (mean < 87)   cm = CmW'(80 - drop_ceil(mean - 80, 77));
      else if (mean < 106)  cm = CmW'(70 - drop_ceil(mean - 87, 211));
      else if (mean < 124)  cm = CmW'(60 - ((mean - 106) >> 1));
      else if (mean < 150)  cm = CmW'(50 - drop_ceil(mean - 124, 288));
      else if (mean < 196)  cm = CmW'(40 - drop_ceil(mean - 150, 511));
      else if (mean < 276)  cm = CmW'(30 - drop_ceil(mean - 196, 888));
      else if (mean < 490)  cm = CmW'(20 - drop_ceil(mean - 276, 2377));
      else if (mean == 490) cm = CmW'(10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void note_sample(logic [SmpW-1:0] smp);
      int unsigned      need;
      int unsigned      n;
      int unsigned      mean;
      logic [CmW-1:0]   cm;
      distance_result_t r;
      sum_acc = sum_acc + 16'(smp);
      need    = (group_len == 0) ? 1 : group_len;
      n       = taken + 1;
      if (n < need) begin
        taken = CntW'(n);
        return;
      end
      // The mean divides by the samples really taken, which matters when the
      // count was lowered in the middle of a group.
      mean    = sum_acc / n;
      sum_acc = '0;
      taken   = '0;
      r.oor   = 1'b1;
      if (mean_to_cm(mean, cm)) begin
        held_cm = cm;
        r.oor   = 1'b0;
      end
      r.dist_cm = held_cm;
      r.mean    = MeanW'(mean);
      awaited.push_back(r);
    endfunction

    function void complain(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s differs: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(logic [CmW-1:0] got_cm, logic [MeanW-1:0] mean, logic oor);
      distance_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited: expected none, actual %0d/%0d/%0d",
                 $time, got_cm, mean, oor);
        return;
      end
      want = awaited.pop_front();
      if (got_cm !== want.dist_cm) complain("distance_cm", want.dist_cm, got_cm);
      if (mean !== want.mean) complain("mean_value", want.mean, mean);
      if (oor !== want.oor)   complain("out_of_range", want.oor, oor);
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CntW-1:0]      cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [SmpW-1:0]      sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CmW-1:0]       distance_cm_o;
  logic [MeanW-1:0]     mean_value_o;
  logic                 out_of_range_o;

  distance_scoreboard sb = new();

  // Idle rates in percent, changed by the stimulus as the run moves on.
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 54;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned rx_hold_request = 0;
  int unsigned random_sent = 0;

  ir_distance_average_linearize #(
    .SAMPLE_BITS(SmpW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_cm_o (distance_cm_o),
    .mean_value_o  (mean_value_o),
    .out_of_range_o(out_of_range_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Offers one sample and returns at the edge where the transaction happens.
  // Valid is left high on return so that a following sample can go out
  // back to back; whoever pauses next lowers it. Each cycle before the offer
  // is idle with the sender's idle rate.
  task automatic send_sample(input logic [SmpW-1:0] v);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(v);
  endtask

  // Writes the sample count once the block has gone quiet: every awaited
  // result has come out and the last sample has had time to settle.
  task automatic set_count(input logic [CntW-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_count(v);
  endtask

  // Sends one group of samples. Most groups scatter around one target mean
  // so that every segment is reached; some sit exactly on or next to a
  // breakpoint, and some are spread over the whole converter range.
  task automatic send_group(input int unsigned len);
    int unsigned kind;
    int          target;
    int          spread;
    int          v;
    kind = $urandom_range(9);
    if (kind < 7) begin
      target = $urandom_range(60, 520);
      spread = $urandom_range(0, 30);
    end else if (kind < 9) begin
      case ($urandom_range(7))
        0:       target = 80;
        1:       target = 87;
        2:       target = 106;
        3:       target = 124;
        4:       target = 150;
        5:       target = 196;
        6:       target = 276;
        default: target = 490;
      endcase
      target = target + $urandom_range(0, 2) - 1;
      spread = 0;
    end else begin
      target = 512;
      spread = 512;
    end
    repeat (len) begin
      v = target + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_sample(SmpW'(v));
      random_sent++;
    end
  endtask

  // Receiver: checks every result transaction and drives ready, either at
  // random or held low for a long stretch on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(distance_cm_o, mean_value_o, out_of_range_o);
      if (rx_hold_request > 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens on either channel for
  // too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned probe_vals[15];
    int unsigned cnt;
    int unsigned eff;
    int unsigned groups;
    int unsigned phase;
    int unsigned r;
    probe_vals = '{600, 0, 80, 81, 86, 87, 100, 106, 107, 124, 150, 196, 276, 490, 1023};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With one sample per group each sample is its own mean.
    // The first one lies above the last breakpoint, so the held distance
    // from reset (zero) must come out with the out-of-range flag. Then come
    // the low clamp, every breakpoint, points inside the segments, the
    // half-slope segment and both converter extremes.
    set_count(CntW'(1));
    foreach (probe_vals[i]) send_sample(SmpW'(probe_vals[i]));

    // A count of zero behaves as a count of one.
    set_count(CntW'(0));
    send_sample(SmpW'(200));
    send_sample(SmpW'(85));

    // Lower the count in the middle of a group: four samples are in, the
    // count drops to two, and the next sample closes a group of five.
    set_count(CntW'(10));
    repeat (4) send_sample(SmpW'(300));
    set_count(CntW'(2));
    send_sample(SmpW'(310));

    // Random part, in phases of one count setting each. The first phases
    // take the extremes; the first one also holds the receiver off so that
    // the block fills up and pushes back on its input.
    phase = 0;
    while (random_sent < RandomSamples) begin
      if (random_sent < RandomSamples / 3) begin
        tx_idle_pct = 37;
        rx_idle_pct = 54;
      end else if (random_sent < 2 * RandomSamples / 3) begin
        tx_idle_pct = 54;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (phase == 0)      cnt = 1;
      else if (phase == 1) cnt = 63;
      else if (phase == 2) cnt = 0;
      else if (r < 60)     cnt = $urandom_range(1, 8);
      else if (r < 85)     cnt = $urandom_range(9, 24);
      else if (r < 96)     cnt = $urandom_range(25, 63);
      else                 cnt = 0;
      set_count(CntW'(cnt));
      eff = (cnt == 0) ? 1 : cnt;
      if (phase == 0) begin
        groups = 40;
        rx_hold_request = HoldOffCycles;
      end else if (eff >= 25) begin
        groups = $urandom_range(2, 3);
      end else begin
        groups = $urandom_range(4, 16);
      end
      repeat (groups) send_group(eff);
      // Sometimes leave a group unfinished, so the next count write lands
      // in the middle of a group.
      if (eff > 1 && $urandom_range(2) == 0) send_group($urandom_range(1, eff - 1));
      phase++;
    end

    // Drain: wait for every awaited result, then give the block time to
    // show any result nobody asked for.
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
